### design/sbt_pkg.sv
package sbt_pkg;

	localparam int ADDR_W = 32;
	localparam int BYTE_W = 8;
	localparam int RANK_W = 6;
	localparam int TBL_W  = ADDR_W + BYTE_W;
	localparam int PADDR_W = 3;
	localparam int Q_DEPTH = 2;

	localparam logic [BYTE_W-1:0] TRAP_RESET = 8'hCC;

	// register index taken from paddr[2]
	localparam logic REG_TRAP_OPCODE = 1'b0;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [2:0] {
		OP_NOP    = 3'd0,
		OP_SHORT  = 3'd1,
		OP_INSERT = 3'd2,
		OP_DELETE = 3'd3,
		OP_CLEAR  = 3'd4
	} cmd_op_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] target_addr;
		logic [BYTE_W-1:0] patch_len;
		logic [BYTE_W-1:0] current_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              write_enable;
		logic [ADDR_W-1:0] write_addr;
		logic [BYTE_W-1:0] write_byte;
		logic              last;
	} result_t;

	typedef struct packed {
		cmd_op_t           op;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] cur;
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(result_t);

endpackage

### design/sbt_ram.sv
module sbt_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 32
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic                                  rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### design/sbt_fifo.sv
module sbt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (pop_ok) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

### design/sbt_front.sv
module sbt_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sbt_pkg::item_t item,
	output logic           full,
	output logic           cmd_valid,
	output sbt_pkg::cmd_t  cmd,
	input  logic           cmd_pop
);

	import sbt_pkg::*;

	cmd_t              cls;
	logic              q_empty;
	logic [CMD_W-1:0]  q_data;

	// length check comes before any table lookup
	always_comb begin
		cls.addr = item.target_addr;
		cls.cur  = item.current_byte;
		case (item.kind)
			KIND_INSERT: cls.op = (item.patch_len == '0) ? OP_SHORT : OP_INSERT;
			KIND_DELETE: cls.op = (item.patch_len == '0) ? OP_SHORT : OP_DELETE;
			KIND_CLEAR:  cls.op = OP_CLEAR;
			default:     cls.op = OP_NOP;
		endcase
	end

	sbt_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (Q_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (cls),
		.full    (full),
		.pop     (cmd_pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	assign cmd_valid = !q_empty;
	assign cmd       = cmd_t'(q_data);

endmodule

### design/sbt_engine.sv
module sbt_engine #(
	parameter int ENTRIES = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [sbt_pkg::BYTE_W-1:0]  trap_opcode,
	input  logic                        cmd_valid,
	input  sbt_pkg::cmd_t               cmd,
	output logic                        cmd_pop,
	input  logic                        res_full,
	output logic                        res_push,
	output sbt_pkg::result_t            res
);

	import sbt_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_DONE  = 6'b000100,
		S_DRAIN = 6'b001000,
		S_LOAD  = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	result_t             res_q;

	logic [CW-1:0]       iss_q;
	logic                chk_vld_s1;
	logic [IW-1:0]       chk_idx_s1;

	logic                hit_q;
	logic [IW-1:0]       hit_idx_q;
	logic [RANK_W-1:0]   hit_rank_q;
	logic [BYTE_W-1:0]   hit_byte_q;
	logic                free_q;
	logic [IW-1:0]       free_idx_q;

	logic [ENTRIES-1:0]  live_q;
	logic [RANK_W-1:0]   rank_q [ENTRIES];
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       drain_q;

	logic                tbl_wr_en;
	logic [TBL_W-1:0]    tbl_rd_data;
	logic                tbl_rd_en;
	logic                ord_wr_en;
	logic                ord_rd_en;
	logic [TBL_W-1:0]    ord_rd_data;

	logic                e_live;
	logic [RANK_W-1:0]   e_rank;
	logic [ADDR_W-1:0]   e_addr;
	logic [BYTE_W-1:0]   e_byte;
	logic                do_insert;
	logic                do_delete;
	logic                emit_ok;
	logic                clear_done;

	assign e_live = chk_vld_s1 && live_q[chk_idx_s1];
	assign e_rank = rank_q[chk_idx_s1];
	assign e_addr = tbl_rd_data[TBL_W-1 -: ADDR_W];
	assign e_byte = tbl_rd_data[BYTE_W-1:0];

	assign tbl_rd_en = (state_q == S_SCAN) && (iss_q != CW'(ENTRIES));
	assign do_insert = (state_q == S_DONE) && (cmd_q.op == OP_INSERT) && !hit_q && free_q;
	assign do_delete = (state_q == S_DONE) && (cmd_q.op == OP_DELETE) && hit_q;
	assign tbl_wr_en = do_insert;
	assign ord_wr_en = e_live && (cmd_q.op == OP_CLEAR);
	assign ord_rd_en = (state_q == S_DRAIN);
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;
	assign emit_ok   = (state_q == S_EMIT) && !res_full;
	assign res_push  = emit_ok;
	assign res       = res_q;
	assign clear_done = emit_ok && (cmd_q.op == OP_CLEAR) && res_q.last;

	sbt_ram #(
		.WIDTH (TBL_W),
		.DEPTH (ENTRIES)
	) u_tbl_ram (
		.clk     (clk),
		.wr_en   (tbl_wr_en),
		.wr_addr (free_idx_q),
		.wr_data ({cmd_q.addr, cmd_q.cur}),
		.rd_en   (tbl_rd_en),
		.rd_addr (iss_q[IW-1:0]),
		.rd_data (tbl_rd_data)
	);

	// restore list, written at each live entry's age rank
	sbt_ram #(
		.WIDTH (TBL_W),
		.DEPTH (ENTRIES)
	) u_ord_ram (
		.clk     (clk),
		.wr_en   (ord_wr_en),
		.wr_addr (e_rank[IW-1:0]),
		.wr_data (tbl_rd_data),
		.rd_en   (ord_rd_en),
		.rd_addr (drain_q[IW-1:0]),
		.rd_data (ord_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			chk_vld_s1 <= 1'b0;
			cnt_q      <= '0;
			live_q     <= '0;
		end else begin
			chk_vld_s1 <= tbl_rd_en;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						if (cmd.op == OP_INSERT || cmd.op == OP_DELETE ||
						    (cmd.op == OP_CLEAR && cnt_q != '0)) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_SCAN: begin
					if (chk_vld_s1 && chk_idx_s1 == IW'(ENTRIES - 1)) begin
						state_q <= (cmd_q.op == OP_CLEAR) ? S_DRAIN : S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_EMIT;
					if (do_insert) begin
						live_q[free_idx_q] <= 1'b1;
						cnt_q <= cnt_q + CW'(1);
					end
					if (do_delete) begin
						live_q[hit_idx_q] <= 1'b0;
						cnt_q <= cnt_q - CW'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_ok) begin
						if (cmd_q.op == OP_CLEAR && !res_q.last) begin
							state_q <= S_DRAIN;
						end else begin
							state_q <= S_IDLE;
						end
						if (clear_done) begin
							live_q <= '0;
							cnt_q  <= '0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_rd_en) begin
			iss_q      <= iss_q + CW'(1);
			chk_idx_s1 <= iss_q[IW-1:0];
		end
		case (state_q)
			S_IDLE: begin
				cmd_q   <= cmd;
				iss_q   <= '0;
				drain_q <= '0;
				hit_q   <= 1'b0;
				free_q  <= 1'b0;
				res_q   <= '{status: (cmd.op == OP_SHORT) ? ST_SHORT : ST_OK,
					write_enable: 1'b0, write_addr: '0, write_byte: '0, last: 1'b1};
			end
			S_SCAN: begin
				if (e_live && !hit_q && e_addr == cmd_q.addr) begin
					hit_q      <= 1'b1;
					hit_idx_q  <= chk_idx_s1;
					hit_rank_q <= e_rank;
					hit_byte_q <= e_byte;
				end
				if (chk_vld_s1 && !e_live && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= chk_idx_s1;
				end
			end
			S_DONE: begin
				if (cmd_q.op == OP_INSERT && !hit_q && !free_q) begin
					res_q.status <= ST_FULL;
				end
				if (do_insert) begin
					res_q.write_enable <= 1'b1;
					res_q.write_addr   <= cmd_q.addr;
					res_q.write_byte   <= trap_opcode;
				end
				if (do_delete) begin
					res_q.write_enable <= 1'b1;
					res_q.write_addr   <= cmd_q.addr;
					res_q.write_byte   <= hit_byte_q;
				end
			end
			S_LOAD: begin
				res_q.status       <= ST_OK;
				res_q.write_enable <= 1'b1;
				res_q.write_addr   <= ord_rd_data[TBL_W-1 -: ADDR_W];
				res_q.write_byte   <= ord_rd_data[BYTE_W-1:0];
				res_q.last         <= (drain_q == cnt_q - CW'(1));
				drain_q            <= drain_q + CW'(1);
			end
			default: ;
		endcase
	end

	// age ranks: 0 is the newest live entry
	for (genvar i = 0; i < ENTRIES; i++) begin : g_rank
		always_ff @(posedge clk) begin
			if (do_insert) begin
				if (free_idx_q == IW'(i)) begin
					rank_q[i] <= '0;
				end else if (live_q[i]) begin
					rank_q[i] <= rank_q[i] + RANK_W'(1);
				end
			end else if (do_delete) begin
				if (live_q[i] && hit_idx_q != IW'(i) && rank_q[i] > hit_rank_q) begin
					rank_q[i] <= rank_q[i] - RANK_W'(1);
				end
			end
		end
	end

endmodule

### design/software_breakpoint_table.sv
// software breakpoint table: holds up to ENTRIES breakpoints, each a code address
// and the code byte that the trap opcode replaced. commands enter through a small
// command queue and results leave through a small result queue, so either side
// may stall without blocking the other. an insert or delete walks the whole table
// through one memory read port, one entry a cycle, then applies its update. remove-all
// walks the table the same way, then restores each live entry, newest first, through
// the drain, load and emit states; short-length, unknown-kind and empty remove-all
// commands skip the walk. the table memories need no clearing pass after reset: the
// live bits decide which entries are used. trap_opcode sits at byte address 0 of the
// register port and may be written only while the block is idle.
module software_breakpoint_table #(
	parameter int ENTRIES = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// command side
	input  logic                         push,
	input  sbt_pkg::item_t               item,
	output logic                         full,
	// result side
	input  logic                         pop,
	output logic                         empty,
	output sbt_pkg::result_t             result,
	// register port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sbt_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	import sbt_pkg::*;

	logic [BYTE_W-1:0] trap_q;
	logic              cmd_valid;
	cmd_t              cmd;
	logic              cmd_pop;
	logic              res_full;
	logic              res_push;
	result_t           res;
	logic [RES_W-1:0]  res_bits;

	// register access: the write lands on the access phase
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TRAP_OPCODE) ? {24'b0, trap_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trap_q <= TRAP_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_TRAP_OPCODE) begin
			trap_q <= pwdata[BYTE_W-1:0];
		end
	end

	// front: classifies each transaction and queues it
	sbt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// back: table walk, updates and result generation
	sbt_engine #(
		.ENTRIES (ENTRIES)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.trap_opcode (trap_q),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop),
		.res_full    (res_full),
		.res_push    (res_push),
		.res         (res)
	);

	// result queue, oldest result shown while not empty
	sbt_fifo #(
		.WIDTH (RES_W),
		.DEPTH (Q_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res),
		.full    (res_full),
		.pop     (pop),
		.rd_data (res_bits),
		.empty   (empty)
	);

	assign result = result_t'(res_bits);

endmodule

### design/sbt_checker.sv
module sbt_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             pop,
	input logic             empty,
	input sbt_pkg::result_t result
);

	import sbt_pkg::*;

	// a result with no write carries zero address and byte
	a_nowrite_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.write_enable) |-> (result.write_addr == '0 && result.write_byte == '0))
		else $error("result without write has nonzero payload");

	// error results never write and always close the transaction
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status != ST_OK) |-> (!result.write_enable && result.last))
		else $error("error result writes or is not last");

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed or vanished");

endmodule

bind software_breakpoint_table sbt_checker u_sbt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.pop    (pop),
	.empty  (empty),
	.result (result)
);
